/* rtl/core/ihc_pkg.sv */
// Shared types and constants for the IPv4 header checker core.
package ihc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam count_t     COUNT_MAX  = '1;
	localparam logic [5:0] MIN_HEADER = 6'd20;
	localparam logic [3:0] IP_VERSION = 4'd4;
	localparam logic [3:0] IHL_MASK   = 4'hf;
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [15:0] SUM_GOOD  = 16'hffff;

	typedef enum logic [2:0] {
		VERDICT_ACCEPT   = 3'd0,
		VERDICT_SHORT    = 3'd1,
		VERDICT_BAD_IHL  = 3'd2,
		VERDICT_BAD_LEN  = 3'd3,
		VERDICT_BAD_SUM  = 3'd4,
		VERDICT_NOT_OURS = 3'd5,
		VERDICT_BAD_PROTO = 3'd6
	} verdict_t;

	typedef enum logic [1:0] {
		KIND_ICMP = 2'd0,
		KIND_UDP  = 2'd1,
		KIND_TCP  = 2'd2
	} kind_t;

	// Per-packet summary word handed from the parser to the judge.
	typedef struct packed {
		logic [7:0]  ver_ihl;
		logic [15:0] total_len;
		logic [7:0]  protocol;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] csum;
		count_t      len;
	} pkt_summary_t;

	function automatic logic [5:0] ihl_bytes(input logic [7:0] ver_ihl);
		logic [3:0] w;
		w = ver_ihl[3:0] & IHL_MASK;
		return {w, 2'b00};
	endfunction

endpackage

/* rtl/core/ihc_front.sv */
// Byte parser: counts bytes, captures header fields, sums header words.
module ihc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 q_full,
	output logic                 sum_push,
	output ihc_pkg::pkt_summary_t sum_word
);
	import ihc_pkg::*;

	count_t      cnt_q;
	logic [7:0]  vhb_q, proto_q, hold_q;
	logic [15:0] tlen_q, acc_q;
	logic [31:0] src_q, dst_q;

	logic [7:0]  vhb_n, proto_n, hold_n;
	logic [15:0] tlen_n, acc_n;
	logic [31:0] src_n, dst_n;
	logic [5:0]  ihl;
	logic [16:0] wsum;
	count_t      len;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign sum_push = accept && last_byte;

	always_comb begin
		vhb_n  = (cnt_q == '0) ? data_byte : vhb_q;
		ihl    = ihl_bytes(vhb_n);
		tlen_n = tlen_q;
		proto_n = proto_q;
		src_n  = src_q;
		dst_n  = dst_q;
		hold_n = hold_q;
		acc_n  = acc_q;
		wsum   = {1'b0, acc_q} + {1'b0, hold_q, data_byte};
		if (cnt_q == count_t'(2)) begin
			tlen_n = {data_byte, 8'h00};
		end else if (cnt_q == count_t'(3)) begin
			tlen_n = {tlen_q[15:8], data_byte};
		end else if (cnt_q == count_t'(9)) begin
			proto_n = data_byte;
		end else if (cnt_q >= count_t'(12) && cnt_q < count_t'(16)) begin
			src_n = {src_q[23:0], data_byte};
		end else if (cnt_q >= count_t'(16) && cnt_q < count_t'(20)) begin
			dst_n = {dst_q[23:0], data_byte};
		end
		if (cnt_q < count_t'(ihl)) begin
			if (!cnt_q[0]) begin
				hold_n = data_byte;
			end else begin
				// end-around carry
				acc_n = wsum[15:0] + {15'd0, wsum[16]};
			end
		end
		len = (cnt_q != COUNT_MAX) ? cnt_q + count_t'(1) : COUNT_MAX;
		sum_word = '{ver_ihl: vhb_n, total_len: tlen_n, protocol: proto_n,
			src: src_n, dst: dst_n, csum: acc_n, len: len};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vhb_q   <= '0;
			tlen_q  <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			acc_q   <= '0;
			hold_q  <= '0;
		end else if (accept) begin
			if (last_byte) begin
				cnt_q   <= '0;
				vhb_q   <= '0;
				tlen_q  <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				acc_q   <= '0;
				hold_q  <= '0;
			end else begin
				cnt_q   <= len;
				vhb_q   <= vhb_n;
				tlen_q  <= tlen_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
				acc_q   <= acc_n;
				hold_q  <= hold_n;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		sum_push |=> (cnt_q == '0 && acc_q == '0))
		else $error("packet state not cleared after last byte");

endmodule

/* rtl/core/ihc_fifo.sv */
// Two-entry queue of packet summary words between parser and judge.
module ihc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ihc_pkg::pkt_summary_t push_word,
	input  logic                  pop,
	output ihc_pkg::pkt_summary_t head_word,
	output logic                  full,
	output logic                  empty
);
	import ihc_pkg::*;

	pkt_summary_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]       cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty     = (cnt_q == '0);
	assign head_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("summary queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("summary queue underflow");

endmodule

/* rtl/core/ihc_back.sv */
// Judge: turns a packet summary into a verdict word and holds it for output.
module ihc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_wdata,
	input  logic                  q_empty,
	input  ihc_pkg::pkt_summary_t head_word,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            verdict,
	output logic [1:0]            protocol_kind,
	output logic [31:0]           source_address,
	output logic [5:0]            payload_offset,
	output logic [15:0]           payload_length
);
	import ihc_pkg::*;

	logic [31:0] local_addr_q;
	logic        valid_q;
	verdict_t    verdict_q, verdict_n;
	kind_t       kind_q, kind_n;
	logic [31:0] src_q;
	logic [5:0]  off_q;
	logic [15:0] plen_q;
	logic [5:0]  ihl;

	assign q_pop = !q_empty && (!valid_q || out_ready);

	always_comb begin
		ihl    = ihl_bytes(head_word.ver_ihl);
		kind_n = KIND_ICMP;
		priority if (head_word.len < count_t'(MIN_HEADER)) begin
			verdict_n = VERDICT_SHORT;
		end else if (head_word.ver_ihl[7:4] != IP_VERSION || ihl < MIN_HEADER
				|| count_t'(ihl) > head_word.len) begin
			verdict_n = VERDICT_BAD_IHL;
		end else if (head_word.total_len < {10'd0, ihl}
				|| count_t'(head_word.total_len) > head_word.len) begin
			verdict_n = VERDICT_BAD_LEN;
		end else if (head_word.csum != SUM_GOOD) begin
			verdict_n = VERDICT_BAD_SUM;
		end else if (head_word.dst != local_addr_q) begin
			verdict_n = VERDICT_NOT_OURS;
		end else if (head_word.protocol == PROTO_ICMP) begin
			verdict_n = VERDICT_ACCEPT;
		end else if (head_word.protocol == PROTO_UDP) begin
			verdict_n = VERDICT_ACCEPT;
			kind_n    = KIND_UDP;
		end else if (head_word.protocol == PROTO_TCP) begin
			verdict_n = VERDICT_ACCEPT;
			kind_n    = KIND_TCP;
		end else begin
			verdict_n = VERDICT_BAD_PROTO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
		end else if (cfg_we) begin
			local_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			verdict_q <= verdict_n;
			if (verdict_n == VERDICT_ACCEPT) begin
				kind_q <= kind_n;
				src_q  <= head_word.src;
				off_q  <= ihl;
				plen_q <= head_word.total_len - {10'd0, ihl};
			end else begin
				kind_q <= KIND_ICMP;
				src_q  <= '0;
				off_q  <= '0;
				plen_q <= '0;
			end
		end
	end

	assign out_valid      = valid_q;
	assign verdict        = verdict_q;
	assign protocol_kind  = kind_q;
	assign source_address = src_q;
	assign payload_offset = off_q;
	assign payload_length = plen_q;

	a_reject_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && verdict_q != VERDICT_ACCEPT) |->
		(src_q == '0 && off_q == '0 && plen_q == '0 && kind_q == KIND_ICMP))
		else $error("rejected word carries nonzero fields");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> valid_q)
		else $error("popped summary not presented");

	a_accept_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && verdict_q == VERDICT_ACCEPT) |-> off_q >= MIN_HEADER)
		else $error("accepted packet with short header offset");

endmodule

/* rtl/core/ipv4_header_checker_core.sv */
// IPv4 header checker: one byte per cycle in while in_ready is high, one verdict word per packet out.
// Throughput: one byte per cycle while the summary queue has room; a packet's verdict queues behind earlier ones.
// Path: the parser pushes the summary into the queue when the last byte is taken; the judge registers the verdict word.
// The byte side stalls only when the two-entry summary queue is full.
// Reset (arst_n low, asynchronous) clears byte count, captured fields, queue and local address.
module ipv4_header_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  verdict,
	output logic [1:0]  protocol_kind,
	output logic [31:0] source_address,
	output logic [5:0]  payload_offset,
	output logic [15:0] payload_length
);
	import ihc_pkg::*;

	pkt_summary_t push_word, head_word;
	logic         push, pop, q_full, q_empty;

	ihc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.sum_push  (push),
		.sum_word  (push_word)
	);

	ihc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.full      (q_full),
		.empty     (q_empty)
	);

	ihc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.q_empty        (q_empty),
		.head_word      (head_word),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.verdict        (verdict),
		.protocol_kind  (protocol_kind),
		.source_address (source_address),
		.payload_offset (payload_offset),
		.payload_length (payload_length)
	);

endmodule
